>>> rtl/rwst_pkg.sv
// rwst_pkg: shared types and constants for the raycast wall stripe texturer.
// No dependencies.
`default_nettype none
package rwst_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TexSzW  = 11;
  localparam int unsigned LhMax   = 24'hFFFFFF;

  typedef enum logic [2:0] {
    REG_EAST_WIDTH   = 3'd0,
    REG_EAST_HEIGHT  = 3'd1,
    REG_WEST_WIDTH   = 3'd2,
    REG_WEST_HEIGHT  = 3'd3,
    REG_SOUTH_WIDTH  = 3'd4,
    REG_SOUTH_HEIGHT = 3'd5,
    REG_NORTH_WIDTH  = 3'd6,
    REG_NORTH_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TEX_EAST  = 2'd0,
    TEX_WEST  = 2'd1,
    TEX_SOUTH = 2'd2,
    TEX_NORTH = 2'd3
  } tex_sel_e;

  // Divider handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [39:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/rwst_divider.sv
// rwst_divider: restoring divider, one quotient bit per cycle, 40 / 24 bits.
// Depends on rwst_pkg.
`default_nettype none
module rwst_divider
  import rwst_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [39:0] quo_q, quo_d;
  logic [24:0] rem_q, rem_d;
  logic [23:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [24:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[23:0], quo_q[39]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = 6'd40;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[38:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  done_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider not busy after start");
  done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");

endmodule
`default_nettype wire

>>> rtl/raycast_wall_stripe_texturer.sv
// raycast_wall_stripe_texturer: column setup and per-pixel texel requests.
// Depends on rwst_pkg and rwst_divider.
// Pixel tick: result registered the next cycle after acceptance; one tick per cycle
//   while no column setup is running and the output is not stalled.
// Column item: input stalled from acceptance until setup ends (hit, texture column,
//   line-height division, rows, texture-step division, start position); a zero wall
//   distance skips the first division, a zero line height ends after rows. No result.
// Reset: span inactive, held state cleared, texture size registers at 64.
`default_nettype none
module raycast_wall_stripe_texturer
  import rwst_pkg::*;
#(
  parameter int unsigned SCREEN_HEIGHT = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind_i,
  input  wire logic [9:0]  column_i,
  input  wire logic        side_i,
  input  wire logic        step_x_positive_i,
  input  wire logic        step_y_positive_i,
  input  wire logic signed [17:0] dir_x_i,
  input  wire logic signed [17:0] dir_y_i,
  input  wire logic [23:0] pos_x_i,
  input  wire logic [23:0] pos_y_i,
  input  wire logic [23:0] wall_distance_i,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [TexSzW-1:0]  cfg_data_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_column_o,
  output logic [9:0]       out_row_o,
  output logic [1:0]       texture_select_o,
  output logic [9:0]       texel_column_o,
  output logic [9:0]       texel_row_o,
  output logic             last_pixel_o
);

  localparam int unsigned Half = SCREEN_HEIGHT / 2;
  localparam logic [39:0] LhNum = 40'(SCREEN_HEIGHT) << 16;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_HIT   = 7'b0000010,
    ST_TXC   = 7'b0000100,
    ST_LHDIV = 7'b0001000,
    ST_ROWS  = 7'b0010000,
    ST_STDIV = 7'b0100000,
    ST_POS   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [TexSzW-1:0] tex_w_q [4];
  logic [TexSzW-1:0] tex_h_q [4];

  logic        span_active_q;
  logic [9:0]  held_column_q, current_row_q, end_row_q, held_texel_column_q;
  logic [1:0]  held_texture_q;
  logic [31:0] texture_position_q, texture_step_q;

  // column setup operands
  logic        c_side_q, c_mirror_q;
  logic [1:0]  c_sel_q;
  logic [9:0]  c_col_q;
  logic [23:0] c_wd_q;
  logic [31:0] c_frac_q;
  logic [23:0] c_lh_q;
  logic [10:0] c_ds_q;
  logic [10:0] c_de_q;
  logic [31:0] c_off_q;
  logic signed [17:0] dir_x_q, dir_y_q;
  logic [23:0] pos_x_q, pos_y_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rwst_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic in_acc, out_acc, tick_fire;
  assign in_stall  = (state_q != ST_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  // setup reads the size registers, so writes wait for idle
  assign cfg_ready = (state_q == ST_IDLE);
  assign out_acc   = out_valid && !out_stall;
  assign tick_fire = in_acc && kind_i && span_active_q;

  // hit coordinate, 24x18 multiply
  logic signed [41:0] hit_prod;
  logic signed [47:0] hit_sum;
  logic [42:0] txc_prod;
  logic [10:0] tw;
  logic [10:0] txc_raw, txc_fin;
  logic [31:0] pos_prod;
  logic [23:0] lh_sat;
  logic [24:0] half_lh;

  assign tw       = tex_w_q[c_sel_q];
  assign hit_prod = $signed({1'b0, c_wd_q}) * (c_side_q ? $signed(dir_x_q) : $signed(dir_y_q));
  assign hit_sum  = $signed({8'd0, c_side_q ? pos_x_q : pos_y_q, 16'd0}) + 48'(hit_prod);
  assign txc_prod = {11'd0, c_frac_q} * {32'd0, tw};
  assign txc_raw  = txc_prod[42:32];
  assign txc_fin  = (tw != '0 && c_mirror_q) ? tw - txc_raw - 11'd1 : txc_raw;
  // only the low 32 bits of the start position are kept
  assign pos_prod = c_off_q * texture_step_q;
  assign lh_sat   = (div_rsp.quotient > 40'(LhMax)) ? 24'(LhMax) : div_rsp.quotient[23:0];
  assign half_lh  = {1'b0, c_lh_q[23:1]};

  always_comb begin
    state_d = state_q;
    div_req = '0;
    case (state_q)
      ST_IDLE:  if (in_acc && !kind_i) state_d = ST_HIT;
      ST_HIT:   state_d = ST_TXC;
      ST_TXC: begin
        if (c_wd_q == '0) begin
          state_d = ST_ROWS;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = LhNum;
          div_req.divisor  = c_wd_q;
          state_d = ST_LHDIV;
        end
      end
      ST_LHDIV: if (div_rsp.done) state_d = ST_ROWS;
      ST_ROWS: begin
        if (c_lh_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {13'd0, tex_h_q[c_sel_q], 16'd0};
          div_req.divisor  = c_lh_q;
          state_d = ST_STDIV;
        end
      end
      ST_STDIV: if (div_rsp.done) state_d = ST_POS;
      ST_POS:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // tick path
  logic [TexSzW-1:0] th;
  logic [15:0] trow;
  logic [9:0]  trow_fin;
  logic [10:0] next_row;
  logic        is_last;
  assign th       = tex_h_q[held_texture_q];
  assign trow     = texture_position_q[31:16];
  assign next_row = {1'b0, current_row_q} + 11'd1;
  assign is_last  = next_row >= {1'b0, end_row_q};
  always_comb begin
    if (th == '0) trow_fin = '0;
    else if ({5'd0, th} <= trow) trow_fin = (th - 11'd1 > 11'd1023) ? 10'd1023 : 10'(th - 11'd1);
    else trow_fin = (trow > 16'd1023) ? 10'd1023 : trow[9:0];
  end

  logic signed [11:0] ds_s;
  always_comb ds_s = 12'(Half) - $signed({1'b0, half_lh[10:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid      <= 1'b0;
      span_active_q  <= 1'b0;
      held_column_q  <= '0;
      current_row_q  <= '0;
      end_row_q      <= '0;
      held_texture_q <= '0;
      held_texel_column_q <= '0;
      texture_position_q  <= '0;
      texture_step_q      <= '0;
      for (int i = 0; i < 4; i++) begin
        tex_w_q[i] <= 11'd64;
        tex_h_q[i] <= 11'd64;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i[0]) tex_h_q[cfg_index_i[2:1]] <= cfg_data_i;
        else tex_w_q[cfg_index_i[2:1]] <= cfg_data_i;
      end
      out_valid <= tick_fire || (out_valid && !out_acc);
      if (tick_fire) begin
        texture_position_q <= texture_position_q + texture_step_q;
        current_row_q      <= next_row[9:0];
        if (is_last) span_active_q <= 1'b0;
      end
      if (in_acc && !kind_i) span_active_q <= 1'b0;
      case (state_q)
        ST_TXC: begin
          held_column_q  <= c_col_q;
          held_texture_q <= c_sel_q;
          held_texel_column_q <= (txc_fin > 11'd1023) ? 10'd1023 : txc_fin[9:0];
        end
        ST_ROWS: begin
          texture_step_q     <= '0;
          texture_position_q <= '0;
        end
        ST_POS: begin
          current_row_q      <= c_ds_q[9:0];
          end_row_q          <= c_de_q[9:0];
          texture_step_q     <= texture_step_q;
          texture_position_q <= pos_prod;
          span_active_q      <= c_ds_q < c_de_q;
        end
        default: ;
      endcase
      if (state_q == ST_STDIV && div_rsp.done) texture_step_q <= div_rsp.quotient[31:0];
    end
  end

  // setup datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && !kind_i) begin
      c_side_q <= side_i;
      c_sel_q  <= side_i ? (step_y_positive_i ? TEX_SOUTH : TEX_NORTH)
                         : (step_x_positive_i ? TEX_EAST : TEX_WEST);
      c_mirror_q <= side_i ? dir_y_i[17] : (!dir_x_i[17] && dir_x_i != '0);
      c_col_q  <= column_i;
      c_wd_q   <= wall_distance_i;
      dir_x_q  <= dir_x_i;
      dir_y_q  <= dir_y_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
    end
    if (state_q == ST_HIT) c_frac_q <= hit_sum[31:0];
    if (state_q == ST_TXC && c_wd_q == '0) c_lh_q <= 24'(LhMax);
    if (state_q == ST_LHDIV && div_rsp.done) c_lh_q <= lh_sat;
    if (state_q == ST_ROWS) begin
      // start row clamps at 0, end row at SCREEN_HEIGHT-1
      if (half_lh >= 25'(Half)) c_ds_q <= '0;
      else c_ds_q <= 11'(ds_s);
      if ({1'b0, half_lh} + 26'(Half) >= 26'(SCREEN_HEIGHT))
        c_de_q <= 11'(SCREEN_HEIGHT - 1);
      else c_de_q <= 11'(half_lh) + 11'(Half);
    end
    if (state_q == ST_STDIV && div_rsp.done)
      c_off_q <= 32'({1'b0, c_ds_q}) - 32'(Half) + 32'(half_lh);
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      out_column_o     <= held_column_q;
      out_row_o        <= current_row_q;
      texture_select_o <= held_texture_q;
      texel_column_o   <= held_texel_column_q;
      texel_row_o      <= trow_fin;
      last_pixel_o     <= is_last;
    end
  end

  // ST_ROWS with zero line height leaves span inactive via column accept clearing
  busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall) else $error("input taken during setup");
  no_span_in_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_POS) |-> !span_active_q)
    else $error("span active during setup");
  stalled_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule
`default_nettype wire
